[src/lli_pkg.sv]
`timescale 1ns / 1ps
package lli_pkg;

  // default coordinate width (signed fixed point word)
  localparam int unsigned COORD_BITS_DEF = 32;
  // width of the parallel threshold register
  localparam int unsigned THR_BITS = 63;

  // sideband that travels with each word down the pipeline
  typedef struct packed {
    logic vld;    // stage holds a live word
    logic par;    // lines parallel or coincident
    logic neg_x;  // x offset is negative
    logic neg_y;  // y offset is negative
  } lli_ctrl_t;

endpackage

[src/lli_in_if.sv]
`timescale 1ns / 1ps
interface lli_in_if #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

[src/lli_out_if.sv]
`timescale 1ns / 1ps
interface lli_out_if #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;
  logic                         clipped;

  modport source (
    output valid, found, cross_x, cross_y, clipped,
    input  ready
  );
  modport sink (
    input  valid, found, cross_x, cross_y, clipped,
    output ready
  );
endinterface

[src/lli_prep.sv]
`timescale 1ns / 1ps
module lli_prep #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [COORD_BITS-1:0]        x1,
  input  logic signed [COORD_BITS-1:0]        y1,
  input  logic signed [COORD_BITS-1:0]        x2,
  input  logic signed [COORD_BITS-1:0]        y2,
  input  logic signed [COORD_BITS-1:0]        x3,
  input  logic signed [COORD_BITS-1:0]        y3,
  input  logic signed [COORD_BITS-1:0]        x4,
  input  logic signed [COORD_BITS-1:0]        y4,
  input  logic [lli_pkg::THR_BITS-1:0]        thr,
  output lli_pkg::lli_ctrl_t                  ctrl_o,
  output logic signed [COORD_BITS-1:0]        base_x_o,
  output logic signed [COORD_BITS-1:0]        base_y_o,
  output logic [2*COORD_BITS+2:0]             d2_o,
  output logic [3*COORD_BITS+3:0]             n2_x_o,
  output logic [3*COORD_BITS+3:0]             n2_y_o
);
  import lli_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = CB + 1;        // coordinate difference
  localparam int unsigned MW  = 2 * DW;        // signed product
  localparam int unsigned SW  = MW + 1;        // difference of products
  localparam int unsigned AW  = 2 * CB + 2;    // magnitude of det / num
  localparam int unsigned NW  = 3 * CB + 4;    // doubled, rounded numerator
  localparam int unsigned CW  = (AW > THR_BITS) ? AW : THR_BITS;

  // stage A: differences and cross products
  logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
  logic                 vld_a_r;
  logic signed [MW-1:0] p1_a_r, r1_a_r, p2_a_r, r2_a_r;
  logic signed [DW-1:0] ax_a_r, ay_a_r;
  logic signed [CB-1:0] x1_a_r, y1_a_r;

  assign ax = $signed({x2[CB-1], x2}) - $signed({x1[CB-1], x1});
  assign ay = $signed({y2[CB-1], y2}) - $signed({y1[CB-1], y1});
  assign bx = $signed({x3[CB-1], x3}) - $signed({x4[CB-1], x4});
  assign by = $signed({y3[CB-1], y3}) - $signed({y4[CB-1], y4});
  assign cx = $signed({x3[CB-1], x3}) - $signed({x1[CB-1], x1});
  assign cy = $signed({y3[CB-1], y3}) - $signed({y1[CB-1], y1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a_r <= ax * by;
      r1_a_r <= ay * bx;
      p2_a_r <= cx * by;
      r2_a_r <= cy * bx;
      ax_a_r <= ax;
      ay_a_r <= ay;
      x1_a_r <= x1;
      y1_a_r <= y1;
    end
  end

  // stage B: determinant, numerator, magnitudes, parallel test
  logic signed [SW-1:0] det, num;
  logic [SW-1:0]        det_abs, num_abs;
  logic [AW-1:0]        det_mag, num_mag;
  logic [DW-1:0]        ax_abs, ay_abs;
  logic [CW-1:0]        det_cmp, thr_cmp;
  logic                 vld_b_r, par_b_r, neg_x_b_r, neg_y_b_r;
  logic [AW-1:0]        det_b_r, num_b_r;
  logic [DW-1:0]        ax_b_r, ay_b_r;
  logic signed [CB-1:0] x1_b_r, y1_b_r;

  assign det     = $signed({p1_a_r[MW-1], p1_a_r}) - $signed({r1_a_r[MW-1], r1_a_r});
  assign num     = $signed({p2_a_r[MW-1], p2_a_r}) - $signed({r2_a_r[MW-1], r2_a_r});
  assign det_abs = det[SW-1] ? SW'(-det) : SW'(det);
  assign num_abs = num[SW-1] ? SW'(-num) : SW'(num);
  assign det_mag = det_abs[AW-1:0];
  assign num_mag = num_abs[AW-1:0];
  assign ax_abs  = ax_a_r[DW-1] ? DW'(-ax_a_r) : DW'(ax_a_r);
  assign ay_abs  = ay_a_r[DW-1] ? DW'(-ay_a_r) : DW'(ay_a_r);
  assign det_cmp = CW'(det_mag);
  assign thr_cmp = CW'(thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_b_r   <= (det_cmp <= thr_cmp);
      neg_x_b_r <= ax_a_r[DW-1] ^ num[SW-1] ^ det[SW-1];
      neg_y_b_r <= ay_a_r[DW-1] ^ num[SW-1] ^ det[SW-1];
      det_b_r   <= det_mag;
      num_b_r   <= num_mag;
      ax_b_r    <= ax_abs;
      ay_b_r    <= ay_abs;
      x1_b_r    <= x1_a_r;
      y1_b_r    <= y1_a_r;
    end
  end

  // stage C: direction times numerator, split in two halves
  logic                 vld_c_r, par_c_r, neg_x_c_r, neg_y_c_r;
  logic [MW-1:0]        pxl_c_r, pxh_c_r, pyl_c_r, pyh_c_r;
  logic [AW-1:0]        det_c_r;
  logic signed [CB-1:0] x1_c_r, y1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_c_r   <= ax_b_r * num_b_r[DW-1:0];
      pxh_c_r   <= ax_b_r * num_b_r[AW-1:DW];
      pyl_c_r   <= ay_b_r * num_b_r[DW-1:0];
      pyh_c_r   <= ay_b_r * num_b_r[AW-1:DW];
      par_c_r   <= par_b_r;
      neg_x_c_r <= neg_x_b_r;
      neg_y_c_r <= neg_y_b_r;
      det_c_r   <= det_b_r;
      x1_c_r    <= x1_b_r;
      y1_c_r    <= y1_b_r;
    end
  end

  // stage D: rounded numerator 2*prod + det and denominator 2*det
  logic [NW-1:0] prod_x, prod_y;
  lli_ctrl_t     ctrl_d_r;

  assign prod_x = (NW'(pxh_c_r) << DW) + NW'(pxl_c_r);
  assign prod_y = (NW'(pyh_c_r) << DW) + NW'(pyl_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_d_r <= '0;
    end else if (en) begin
      ctrl_d_r <= '{vld: vld_c_r, par: par_c_r, neg_x: neg_x_c_r, neg_y: neg_y_c_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_x_o   <= (prod_x << 1) + NW'(det_c_r);
      n2_y_o   <= (prod_y << 1) + NW'(det_c_r);
      d2_o     <= {det_c_r, 1'b0};
      base_x_o <= x1_c_r;
      base_y_o <= y1_c_r;
    end
  end

  assign ctrl_o = ctrl_d_r;

endmodule

[src/lli_div_cell.sv]
`timescale 1ns / 1ps
module lli_div_cell #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int unsigned SHIFT      = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  lli_pkg::lli_ctrl_t           ctrl_i,
  input  logic signed [COORD_BITS-1:0] base_x_i,
  input  logic signed [COORD_BITS-1:0] base_y_i,
  input  logic [2*COORD_BITS+2:0]      d2_i,
  input  logic [3*COORD_BITS+3:0]      rem_x_i,
  input  logic [3*COORD_BITS+3:0]      rem_y_i,
  input  logic [COORD_BITS+1:0]        q_x_i,
  input  logic [COORD_BITS+1:0]        q_y_i,
  output lli_pkg::lli_ctrl_t           ctrl_o,
  output logic signed [COORD_BITS-1:0] base_x_o,
  output logic signed [COORD_BITS-1:0] base_y_o,
  output logic [2*COORD_BITS+2:0]      d2_o,
  output logic [3*COORD_BITS+3:0]      rem_x_o,
  output logic [3*COORD_BITS+3:0]      rem_y_o,
  output logic [COORD_BITS+1:0]        q_x_o,
  output logic [COORD_BITS+1:0]        q_y_o
);
  import lli_pkg::*;

  localparam int unsigned NW = 3 * COORD_BITS + 4;
  localparam int unsigned QW = COORD_BITS + 2;

  logic [NW-1:0] dsh;
  logic [NW:0]   trial_x, trial_y;

  // one restoring step: subtract the shifted divisor where it fits
  assign dsh     = NW'(d2_i) << SHIFT;
  assign trial_x = {1'b0, rem_x_i} - {1'b0, dsh};
  assign trial_y = {1'b0, rem_y_i} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o <= '0;
    end else if (en) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_x_o <= base_x_i;
      base_y_o <= base_y_i;
      d2_o     <= d2_i;
      rem_x_o  <= trial_x[NW] ? rem_x_i : trial_x[NW-1:0];
      rem_y_o  <= trial_y[NW] ? rem_y_i : trial_y[NW-1:0];
      q_x_o    <= {q_x_i[QW-2:0], ~trial_x[NW]};
      q_y_o    <= {q_y_i[QW-2:0], ~trial_y[NW]};
    end
  end

endmodule

[src/line_line_intersection_unit.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Word
// in_ch    in   valid / ready  two lines, four points, signed fixed point
// out_ch   out  valid / ready  found, cross_x, cross_y, clipped
// cfg      in   cfg_we         parallel threshold, cfg_wdata
//
// One word enters per cycle while the output is not stalled; the pipeline has
// four set-up stages, COORD_BITS + 2 divider cells and one output stage.
// The divider cell row sets the latency, each cell retiring one quotient bit.
// Reset is synchronous, active low; it clears valid flags and the threshold.
// A stalled output freezes the whole pipeline; in_ch.ready drops with it.
module line_line_intersection_unit #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lli_in_if.sink                       in_ch,
  lli_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [lli_pkg::THR_BITS-1:0] cfg_wdata
);
  import lli_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned QW  = CB + 2;          // quotient bits incl. overflow bit
  localparam int unsigned NW  = 3 * CB + 4;
  localparam int unsigned D2W = 2 * CB + 3;
  localparam int unsigned VW  = CB + 3;          // base plus offset, before saturation
  localparam logic signed [VW-1:0] HI = VW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  // Global advance: move every stage whenever the output word is free or taken.
  logic en;
  logic out_vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Threshold register; the user must write it only while the pipeline is empty (not enforced).
  logic [THR_BITS-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Chain of divider cells; index 0 is the set-up output.
  lli_ctrl_t            ctrl   [0:QW];
  logic signed [CB-1:0] base_x [0:QW];
  logic signed [CB-1:0] base_y [0:QW];
  logic [D2W-1:0]       d2     [0:QW];
  logic [NW-1:0]        rem_x  [0:QW];
  logic [NW-1:0]        rem_y  [0:QW];
  logic [QW-1:0]        q_x    [0:QW];
  logic [QW-1:0]        q_y    [0:QW];

  lli_prep #(.COORD_BITS(CB)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .x1       (in_ch.a_start_x),
    .y1       (in_ch.a_start_y),
    .x2       (in_ch.a_end_x),
    .y2       (in_ch.a_end_y),
    .x3       (in_ch.b_start_x),
    .y3       (in_ch.b_start_y),
    .x4       (in_ch.b_end_x),
    .y4       (in_ch.b_end_y),
    .thr      (thr_r),
    .ctrl_o   (ctrl[0]),
    .base_x_o (base_x[0]),
    .base_y_o (base_y[0]),
    .d2_o     (d2[0]),
    .n2_x_o   (rem_x[0]),
    .n2_y_o   (rem_y[0])
  );

  assign q_x[0] = '0;
  assign q_y[0] = '0;

  // Cell k tries the divisor shifted by QW-1-k; the first cell flags overflow.
  for (genvar k = 0; k < QW; k++) begin : g_cell
    lli_div_cell #(.COORD_BITS(CB), .SHIFT(QW - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctrl_i   (ctrl[k]),
      .base_x_i (base_x[k]),
      .base_y_i (base_y[k]),
      .d2_i     (d2[k]),
      .rem_x_i  (rem_x[k]),
      .rem_y_i  (rem_y[k]),
      .q_x_i    (q_x[k]),
      .q_y_i    (q_y[k]),
      .ctrl_o   (ctrl[k+1]),
      .base_x_o (base_x[k+1]),
      .base_y_o (base_y[k+1]),
      .d2_o     (d2[k+1]),
      .rem_x_o  (rem_x[k+1]),
      .rem_y_o  (rem_y[k+1]),
      .q_x_o    (q_x[k+1]),
      .q_y_o    (q_y[k+1])
    );
  end

  // Output stage: apply the rounded offset, saturate, zero a parallel result.
  logic signed [VW-1:0] off_x, off_y, sum_x, sum_y;
  logic signed [VW-1:0] sat_x, sat_y;
  logic                 clip_x, clip_y;
  lli_ctrl_t            fin;

  assign fin   = ctrl[QW];
  assign off_x = $signed(VW'(q_x[QW][QW-2:0]));
  assign off_y = $signed(VW'(q_y[QW][QW-2:0]));
  assign sum_x = fin.neg_x ? VW'(base_x[QW]) - off_x : VW'(base_x[QW]) + off_x;
  assign sum_y = fin.neg_y ? VW'(base_y[QW]) - off_y : VW'(base_y[QW]) + off_y;

  always_comb begin
    clip_x = 1'b1;
    if (q_x[QW][QW-1]) begin
      sat_x = fin.neg_x ? LO : HI;
    end else if (sum_x > HI) begin
      sat_x = HI;
    end else if (sum_x < LO) begin
      sat_x = LO;
    end else begin
      sat_x  = sum_x;
      clip_x = 1'b0;
    end
  end

  always_comb begin
    clip_y = 1'b1;
    if (q_y[QW][QW-1]) begin
      sat_y = fin.neg_y ? LO : HI;
    end else if (sum_y > HI) begin
      sat_y = HI;
    end else if (sum_y < LO) begin
      sat_y = LO;
    end else begin
      sat_y  = sum_y;
      clip_y = 1'b0;
    end
  end

  logic                 found_r, clipped_r;
  logic signed [CB-1:0] cross_x_r, cross_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fin.vld;
    end
  end

  // Hold the word while the sink stalls; drop in the next one otherwise.
  always_ff @(posedge clk) begin
    if (en) begin
      found_r   <= !fin.par;
      cross_x_r <= fin.par ? '0 : sat_x[CB-1:0];
      cross_y_r <= fin.par ? '0 : sat_y[CB-1:0];
      clipped_r <= !fin.par && (clip_x || clip_y);
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.found   = found_r;
  assign out_ch.cross_x = cross_x_r;
  assign out_ch.cross_y = cross_y_r;
  assign out_ch.clipped = clipped_r;

endmodule
